@@ rtl/core/bsm3_pkg.sv @@
// Shared constants for the 3x3 binomial smoothing filter.
package bsm3_pkg;

  // Parameter defaults
  localparam int DEF_MAX_WIDTH   = 1024;
  localparam int DEF_SAMPLE_BITS = 16;

  // Configuration register layout
  localparam int CFG_INDEX_BITS  = 2;
  localparam int CFG_DATA_BITS   = 16;
  localparam int WIDTH_REG_BITS  = 11;
  localparam int HEIGHT_REG_BITS = 16;

  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 2'd1;

  localparam int RESET_FRAME_WIDTH  = 1024;
  localparam int RESET_FRAME_HEIGHT = 1024;
  localparam int MIN_DIM            = 3;

  // Result queue depth; must cover the two in-flight stages plus one.
  localparam int OUT_FIFO_DEPTH = 4;

endpackage

@@ rtl/core/bsm3_line_mem.sv @@
// Line store RAM (two rows packed per word) with write-to-read forwarding.
module bsm3_line_mem #(
  parameter int DEPTH = bsm3_pkg::DEF_MAX_WIDTH,
  parameter int DW    = 2 * bsm3_pkg::DEF_SAMPLE_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DW-1:0]            rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DW-1:0]            wr_data
);

  logic [DW-1:0] mem_r [DEPTH];
  logic [DW-1:0] rd_r;
  logic [DW-1:0] fwd_data_r;
  logic          fwd_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_r <= mem_r[rd_addr];
    end
  end

  // Same-cycle read of the entry being written returns the new word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (rd_en) begin
      fwd_r <= wr_en && (wr_addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_data_r <= wr_data;
    end
  end

  assign rd_data = fwd_r ? fwd_data_r : rd_r;

endmodule

@@ rtl/core/bsm3_out_fifo.sv @@
// Small result queue that decouples the filter pipeline from the output stream.
module bsm3_out_fifo #(
  parameter int DW    = bsm3_pkg::DEF_SAMPLE_BITS + 1,
  parameter int DEPTH = bsm3_pkg::OUT_FIFO_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [DW-1:0]              push_data,
  input  logic                       pop,
  output logic                       pop_valid,
  output logic [DW-1:0]              pop_data,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DW-1:0]    buf_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_pop;

  assign do_pop = pop && (cnt_r != '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (!push && do_pop) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_valid = (cnt_r != '0);
  assign pop_data  = buf_r[rd_ptr_r];
  assign count     = cnt_r;

endmodule

@@ rtl/core/binomial_smooth_3x3.sv @@
// Top level of the 3x3 binomial (1-2-1 x 1-2-1) smoothing filter with two line stores.
//
//  port group | dir | fields (low bit up)                | request taken when
//  -----------+-----+------------------------------------+---------------------------
//  in_*       | in  | tdata: sample; tuser: is_flush     | in_tvalid & in_tready
//  out_*      | out | tdata: smoothed; tlast: last       | out_tvalid & out_tready
//  cfg_*      | in  | index: register; data: value       | cfg_valid & cfg_ready
//
//  One request per clock sustained while in_tready is high. The result a request causes
//  passes through line store read, then window shift plus store write-back, then kernel
//  sum plus rounding, and then enters the queue.
//  The line store is one RAM holding both rows above per column, one read-modify-write
//  per request; a read of the column written in the same cycle is forwarded.
//  in_tready drops only when the 4-entry result queue plus the two in-flight stages
//  would overflow. Reset (rst_n low, synchronous) clears counters, window and queue;
//  line store contents are left as they are and need no clearing pass. cfg_ready is
//  always high.
module binomial_smooth_3x3 #(
  parameter int MAX_WIDTH   = bsm3_pkg::DEF_MAX_WIDTH,
  parameter int SAMPLE_BITS = bsm3_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  // Input stream
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]        in_tdata,   // [SAMPLE_BITS-1:0] sample
  input  logic                                    in_tuser,   // [0] is_flush
  // Result stream
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]        out_tdata,  // [SAMPLE_BITS-1:0] smoothed
  output logic                                    out_tlast,
  // Configuration writes
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [bsm3_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [bsm3_pkg::CFG_DATA_BITS-1:0]      cfg_data
);

  localparam int S     = SAMPLE_BITS;
  localparam int TDW   = ((S + 7) / 8) * 8;
  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int CW    = $clog2(MAX_WIDTH + 1);
  localparam int PW    = $clog2(MAX_WIDTH + 2);
  localparam int HB    = bsm3_pkg::HEIGHT_REG_BITS;
  localparam int WB    = bsm3_pkg::WIDTH_REG_BITS;
  localparam int FD    = bsm3_pkg::OUT_FIFO_DEPTH;
  localparam int FCW   = $clog2(FD + 1);
  localparam int QW    = FCW + 1;
  localparam int W_RST = (bsm3_pkg::RESET_FRAME_WIDTH > MAX_WIDTH) ?
                         MAX_WIDTH : bsm3_pkg::RESET_FRAME_WIDTH;

  // ---------------------------------------------------------------------------
  // Configuration: effective (clamped) frame size is stored directly.
  // ---------------------------------------------------------------------------
  logic          cfg_wr;
  logic          cfg_hit;
  logic [31:0]   cfg_w32;
  logic [CW-1:0] cfg_w_eff;
  logic [HB-1:0] cfg_h_eff;
  logic [CW-1:0] w_eff_r;
  logic [HB-1:0] h_eff_r;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign cfg_hit   = cfg_wr && ((cfg_index == bsm3_pkg::REG_FRAME_WIDTH) ||
                                (cfg_index == bsm3_pkg::REG_FRAME_HEIGHT));

  always_comb begin
    cfg_w32 = 32'(cfg_data[WB-1:0]);
    if (cfg_w32 < 32'(bsm3_pkg::MIN_DIM)) begin
      cfg_w_eff = CW'(bsm3_pkg::MIN_DIM);
    end else if (cfg_w32 > 32'(MAX_WIDTH)) begin
      cfg_w_eff = CW'(MAX_WIDTH);
    end else begin
      cfg_w_eff = cfg_w32[CW-1:0];
    end
    cfg_h_eff = (cfg_data[HB-1:0] < HB'(bsm3_pkg::MIN_DIM)) ?
                HB'(bsm3_pkg::MIN_DIM) : cfg_data[HB-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_eff_r <= CW'(W_RST);
      h_eff_r <= HB'(bsm3_pkg::RESET_FRAME_HEIGHT);
    end else if (cfg_wr) begin
      unique case (cfg_index)
        bsm3_pkg::REG_FRAME_WIDTH:  w_eff_r <= cfg_w_eff;
        bsm3_pkg::REG_FRAME_HEIGHT: h_eff_r <= cfg_h_eff;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: position tracking, line store read issue.
  // ---------------------------------------------------------------------------
  logic          in_acc;
  logic          flushing;
  logic          consume;
  logic [AW-1:0] col_r, col_nxt;
  logic [HB-1:0] row_r, row_nxt;
  logic [PW-1:0] pend_r, pend_nxt;

  logic          pos_wrap;
  logic [AW-1:0] c0;
  logic [HB-1:0] r0;
  logic [CW-1:0] c_inc;
  logic [HB-1:0] r_inc;
  logic          eol, eof;
  logic          n_emit, n_border;
  logic [PW-1:0] flush_k;
  logic          f_last;
  logic [AW-1:0] f_addr;
  logic [AW-1:0] s0_addr;

  assign in_acc   = in_tvalid && in_tready;
  assign flushing = (pend_r != '0);
  // A flush outside the flush phase is taken and dropped
  assign consume  = in_acc && (flushing || !in_tuser);

  always_comb begin
    pos_wrap = (CW'(col_r) >= w_eff_r) || (row_r >= h_eff_r);
    c0       = pos_wrap ? '0 : col_r;
    r0       = pos_wrap ? '0 : row_r;
    c_inc    = CW'(c0) + CW'(1);
    r_inc    = r0 + HB'(1);
    eol      = (c_inc == w_eff_r);
    eof      = eol && (r_inc == h_eff_r);
    // First result appears once the center of row 0, col 0 has a full window
    n_emit   = (r0 >= HB'(2)) || ((r0 == HB'(1)) && (c0 != '0));
    // Center is on the left/right edge when c0 is 0 or 1, top edge when r0 is 1
    n_border = (c0 < AW'(2)) || (r0 == HB'(1));
    // Flush step k runs 0..w; step w reuses column 0
    flush_k  = PW'(w_eff_r) + PW'(1) - pend_r;
    f_last   = (pend_r == PW'(1));
    f_addr   = f_last ? '0 : flush_k[AW-1:0];
    s0_addr  = flushing ? f_addr : c0;
  end

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    pend_nxt = pend_r;
    if (cfg_hit) begin
      col_nxt  = '0;
      row_nxt  = '0;
      pend_nxt = '0;
    end else if (consume) begin
      if (flushing) begin
        pend_nxt = pend_r - PW'(1);
      end else begin
        col_nxt = eol ? '0 : c_inc[AW-1:0];
        row_nxt = eol ? (eof ? '0 : r_inc) : r0;
        if (eof) begin
          pend_nxt = PW'(w_eff_r) + PW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      pend_r <= '0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      pend_r <= pend_nxt;
    end
  end

  // Stage 1 registers
  logic                s1_v_r;
  logic [AW-1:0]       s1_addr_r;
  logic signed [S-1:0] s1_val_r;
  logic                s1_emit_r;
  logic                s1_border_r;
  logic                s1_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= consume;
    end
  end

  always_ff @(posedge clk) begin
    if (consume) begin
      s1_addr_r   <= s0_addr;
      s1_val_r    <= flushing ? '0 : signed'(in_tdata[S-1:0]);
      s1_emit_r   <= flushing || n_emit;
      // Every flush result is on the last row or the right column
      s1_border_r <= flushing || n_border;
      s1_last_r   <= flushing && f_last;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: line store data back, shift window, write the column back.
  // Word layout: {row two above, row above}.
  // ---------------------------------------------------------------------------
  logic [2*S-1:0]      ls_rd_data;
  logic [2*S-1:0]      ls_wr_data;
  logic signed [S-1:0] col_top;
  logic signed [S-1:0] col_mid;

  assign col_top    = signed'(ls_rd_data[2*S-1:S]);
  assign col_mid    = signed'(ls_rd_data[S-1:0]);
  assign ls_wr_data = {ls_rd_data[S-1:0], s1_val_r};

  bsm3_line_mem #(
    .DEPTH (MAX_WIDTH),
    .DW    (2 * S)
  ) u_line_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (consume),
    .rd_addr (s0_addr),
    .rd_data (ls_rd_data),
    .wr_en   (s1_v_r),
    .wr_addr (s1_addr_r),
    .wr_data (ls_wr_data)
  );

  // 3x3 window, row-major: [0..2] two rows up, [3..5] row above, [6..8] current
  logic signed [S-1:0] win_r [9];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= '0;
      end
    end else if (s1_v_r) begin
      win_r[0] <= win_r[1];
      win_r[1] <= win_r[2];
      win_r[2] <= col_top;
      win_r[3] <= win_r[4];
      win_r[4] <= win_r[5];
      win_r[5] <= col_mid;
      win_r[6] <= win_r[7];
      win_r[7] <= win_r[8];
      win_r[8] <= s1_val_r;
    end
  end

  logic s2_v_r;
  logic s2_border_r;
  logic s2_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r && s1_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      s2_border_r <= s1_border_r;
      s2_last_r   <= s1_last_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: weighted sum, round half up, divide by 16; border pixels pass the center through.
  // ---------------------------------------------------------------------------
  logic signed [S+3:0] ksum;
  logic signed [S+3:0] krnd;
  logic signed [S-1:0] smooth;
  logic [S:0]          res_word;

  always_comb begin
    ksum = (S+4)'(win_r[0]) + ((S+4)'(win_r[1]) <<< 1) + (S+4)'(win_r[2])
         + ((S+4)'(win_r[3]) <<< 1) + ((S+4)'(win_r[4]) <<< 2)
         + ((S+4)'(win_r[5]) <<< 1)
         + (S+4)'(win_r[6]) + ((S+4)'(win_r[7]) <<< 1) + (S+4)'(win_r[8]);
    krnd     = ksum + (S+4)'(8);
    smooth   = s2_border_r ? win_r[4] : krnd[S+3:4];
    res_word = {s2_last_r, smooth};
  end

  // ---------------------------------------------------------------------------
  // Result queue and input back-pressure
  // ---------------------------------------------------------------------------
  logic [FCW-1:0] fifo_cnt;
  logic [S:0]     fifo_data;
  logic [QW-1:0]  occupancy;

  bsm3_out_fifo #(
    .DW    (S + 1),
    .DEPTH (FD)
  ) u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s2_v_r),
    .push_data (res_word),
    .pop       (out_tready),
    .pop_valid (out_tvalid),
    .pop_data  (fifo_data),
    .count     (fifo_cnt)
  );

  // Reserve a queue slot for everything already in flight
  assign occupancy = QW'(fifo_cnt) + QW'(s1_v_r) + QW'(s2_v_r);
  assign in_tready = (occupancy < QW'(FD));

  assign out_tdata = TDW'(fifo_data[S-1:0]);
  assign out_tlast = fifo_data[S];

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r |-> (fifo_cnt < FCW'(FD)))
    else $error("result pushed into a full queue");

  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    CW'(col_r) < w_eff_r)
    else $error("column counter beyond frame width");

  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    PW'(pend_r) <= PW'(w_eff_r) + PW'(1))
    else $error("flush count beyond width + 1");

  a_flush_at_origin: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r != '0) |-> ((col_r == '0) && (row_r == '0)))
    else $error("flush phase with position counters not at frame start");

  a_last_from_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (consume && !flushing) |=> !s1_last_r)
    else $error("frame end marked outside the flush phase");

endmodule

@@ dv/tb_binomial_smooth_3x3.sv @@
// Self-checking testbench for binomial_smooth_3x3: scoreboard with window predictor, drivers.
`timescale 1ns / 1ps

module tb_binomial_smooth_3x3;
  import bsm3_pkg::*;

  localparam int SW          = DEF_SAMPLE_BITS;
  localparam int TDATA_BITS  = ((SW + 7) / 8) * 8;
  localparam int LINE_DEPTH  = DEF_MAX_WIDTH;
  localparam int KERNEL [9]  = '{1, 2, 1, 2, 4, 2, 1, 2, 1};

  // Index with no register behind it; a write there must leave the frame alone.
  localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS  = 1000;
  localparam int SETTLE_CYCLES = 10;     // pipeline is 3 deep plus the result queue
  localparam int LONG_HOLD     = 300;    // result side hold-off, well past queue depth
  localparam int CYCLE_LIMIT   = 150000;

  logic                      clk;
  logic                      rst_n      = 1'b0;
  logic                      in_tvalid  = 1'b0;
  logic                      in_tready;
  logic [TDATA_BITS-1:0]     in_tdata   = '0;  // [15:0] sample
  logic                      in_tuser   = 1'b0; // [0] is_flush
  logic                      out_tvalid;
  logic                      out_tready = 1'b0;
  logic [TDATA_BITS-1:0]     out_tdata;         // [15:0] smoothed
  logic                      out_tlast;
  logic                      cfg_valid  = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index  = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data   = '0;

  bit          idle_on     = 1'b1;
  int unsigned stall_asks  = 0;
  int unsigned item_count  = 0;
  int unsigned cycle_count = 0;

  typedef struct packed {
    logic [SW-1:0] smoothed;
    logic          last;
  } pixel_t;

  // Scoreboard: tracks line stores, 3x3 window and frame position, and keeps the
  // queue of pixels the block still owes us.
  class smooth_scoreboard;
    int unsigned        width_reg, height_reg;
    logic signed [SW-1:0] line_above     [LINE_DEPTH];
    logic signed [SW-1:0] line_two_above [LINE_DEPTH];
    logic signed [SW-1:0] win [9];
    int unsigned        col, row, flush_owed;
    pixel_t             expected_pixels [$];
    int unsigned        errors;

    function new();
      width_reg  = RESET_FRAME_WIDTH;
      height_reg = RESET_FRAME_HEIGHT;
      for (int i = 0; i < LINE_DEPTH; i++) begin
        line_above[i]     = '0;
        line_two_above[i] = '0;
      end
      for (int i = 0; i < 9; i++) win[i] = '0;
      col = 0;
      row = 0;
      flush_owed = 0;
      errors = 0;
    endfunction

    function int unsigned eff_width();
      int unsigned w;
      w = width_reg;
      if (w < MIN_DIM) w = MIN_DIM;
      if (w > LINE_DEPTH) w = LINE_DEPTH;
      return w;
    endfunction

    function int unsigned eff_height();
      return (height_reg < MIN_DIM) ? MIN_DIM : height_reg;
    endfunction

    // Any real register write aborts the frame; stores and window are kept.
    function void write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
      if (idx == REG_FRAME_WIDTH) width_reg = data[WIDTH_REG_BITS-1:0];
      else if (idx == REG_FRAME_HEIGHT) height_reg = data[HEIGHT_REG_BITS-1:0];
      else return;
      col = 0;
      row = 0;
      flush_owed = 0;
    endfunction

    function void push_column(int unsigned c, logic signed [SW-1:0] v);
      logic signed [SW-1:0] top, mid;
      if (c >= LINE_DEPTH) c = 0;
      top = line_two_above[c];
      mid = line_above[c];
      line_two_above[c] = mid;
      line_above[c] = v;
      for (int r = 0; r < 3; r++) begin
        win[r*3]   = win[r*3+1];
        win[r*3+1] = win[r*3+2];
      end
      win[2] = top;
      win[5] = mid;
      win[8] = v;
    endfunction

    // Border pixels pass through; interior gets (sum + 8) >>> 4.
    function logic [SW-1:0] center_value(int rr, int cc, int w, int h);
      longint acc;
      if (rr == 0 || rr + 1 >= h || cc == 0 || cc + 1 >= w) return win[4];
      acc = 0;
      for (int i = 0; i < 9; i++) acc += KERNEL[i] * win[i];
      acc = (acc + 8) >>> 4;
      return acc[SW-1:0];
    endfunction

    function void note_request(logic [SW-1:0] pix, logic is_flush);
      int unsigned w, h, r, c, k;
      int          rr, cc;
      bit          emit;
      pixel_t      px;
      w = eff_width();
      h = eff_height();
      if (flush_owed == 0) begin
        if (is_flush) return;              // nothing owed: flush is dropped
        r = row;
        c = col;
        if (c >= w || r >= h) begin
          r = 0;
          c = 0;
        end
        push_column(c, pix);
        emit = (r >= 2) || (r == 1 && c >= 1);
        if (c >= 1) begin
          rr = int'(r) - 1;
          cc = int'(c) - 1;
        end else begin
          rr = int'(r) - 2;
          cc = int'(w) - 1;
        end
        c++;
        if (c == w) begin
          c = 0;
          r++;
          if (r == h) begin
            r = 0;
            flush_owed = w + 1;
          end
        end
        row = r;
        col = c;
        if (!emit) return;
        px.smoothed = center_value(rr, cc, w, h);
        px.last     = 1'b0;
      end else begin
        // flush phase: any request, sample or not, pushes one pixel out
        if (flush_owed > w + 1) flush_owed = w + 1;
        k = w + 1 - flush_owed;
        push_column((k < w) ? k : 0, '0);
        if (k == 0) begin
          rr = int'(h) - 2;
          cc = int'(w) - 1;
        end else begin
          rr = int'(h) - 1;
          cc = int'(k) - 1;
        end
        px.smoothed = center_value(rr, cc, w, h);
        flush_owed--;
        px.last = (flush_owed == 0);
      end
      expected_pixels.insert(expected_pixels.size(), px);
    endfunction

    function void check_result(logic [SW-1:0] smoothed, logic last);
      pixel_t want;
      if (expected_pixels.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got smoothed %h last %b",
                 $time, smoothed, last);
        return;
      end
      want = expected_pixels.pop_front();
      if (smoothed !== want.smoothed) begin
        errors++;
        $display("%0t: smoothed mismatch, expected %h, got %h", $time, want.smoothed, smoothed);
      end
      if (last !== want.last) begin
        errors++;
        $display("%0t: tlast mismatch, expected %b, got %b", $time, want.last, last);
      end
    endfunction
  endclass

  smooth_scoreboard sb = new();

  binomial_smooth_3x3 uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case a handshake never completes.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("binomial_smooth_3x3 verification failed");
      $finish;
    end
  end

  // Monitor: every accepted request goes to the scoreboard at the edge it is taken.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_tvalid && in_tready) sb.note_request(in_tdata[SW-1:0], in_tuser);
      if (out_tvalid && out_tready) sb.check_result(out_tdata[SW-1:0], out_tlast);
    end
  end

  // Result sink: random back-pressure, plus a long hold-off whenever stall_asks moves.
  initial begin : result_sink
    int          hold_left;
    int unsigned asks_seen;
    hold_left = 0;
    asks_seen = 0;
    forever begin
      @(posedge clk);
      if (stall_asks != asks_seen) begin
        asks_seen = stall_asks;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= !(idle_on && $urandom_range(0, 99) < 6);
      end
    end
  end

  // One input request; tvalid stays up afterwards so back-to-back requests have no gap.
  task automatic send_item(input logic [SW-1:0] pix, input logic is_flush);
    cfg_valid <= 1'b0;
    while (idle_on && $urandom_range(0, 99) < 6) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= TDATA_BITS'(pix);
    in_tuser  <= is_flush;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Register write; cfg_valid is lowered by whatever the next activity is.
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Stop sending and let every owed pixel come out, then give the pipe time to settle.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    cfg_valid <= 1'b0;
    do begin
      while (sb.expected_pixels.size() != 0) @(posedge clk);
      repeat (SETTLE_CYCLES) @(posedge clk);
    end while (sb.expected_pixels.size() != 0);
  endtask

  function automatic logic [SW-1:0] next_sample();
    case ($urandom_range(0, 15))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return SW'($urandom);
    endcase
  endfunction

  // Frame samples, with the odd stray flush mixed in (dropped by the block outside a flush tail, not counted).
  task automatic send_samples(input int unsigned n);
    repeat (n) begin
      if ($urandom_range(0, 32) == 0) send_item(SW'($urandom), 1'b1);
      send_item(next_sample(), 1'b0);
      item_count++;
    end
  endtask

  // Flush tail; now and then a sample stands in for a flush and its value gets dropped.
  task automatic send_flushes(input int unsigned n);
    repeat (n) begin
      if ($urandom_range(0, 19) == 0) send_item(next_sample(), 1'b0);
      else send_item(SW'($urandom), 1'b1);
      item_count++;
    end
  endtask

  initial begin : stimulus
    int unsigned          w, h, cur_w, cur_h, frames, phase, wsel, hsel;
    bit                   cut;
    logic [CFG_DATA_BITS-1:0] w_raw, h_raw;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: smallest frame, width below minimum, height below minimum.
    write_reg(REG_FRAME_WIDTH, 16'h0000);
    write_reg(REG_FRAME_HEIGHT, 16'h0001);
    send_item(16'h1234, 1'b1);             // flush with nothing owed: ignored
    repeat (9) send_item(16'h7FFF, 1'b0);  // interior at full positive scale
    repeat (4) send_item(16'h0000, 1'b1);
    repeat (9) send_item(16'h8000, 1'b0);  // interior at full negative scale
    send_item(16'h5555, 1'b0);             // sample in the flush tail, value dropped
    repeat (3) send_item(16'hFFFF, 1'b1);
    wait_idle();

    // The result side holds off for a long stretch while samples keep coming, so the
    // block backs up onto in_tready.
    write_reg(REG_FRAME_WIDTH, 16'd16);
    write_reg(REG_FRAME_HEIGHT, 16'd6);
    stall_asks <= stall_asks + 1;
    send_samples(16 * 6);
    send_flushes(16 + 1);
    wait_idle();
    cur_w = 16;
    cur_h = 6;

    // Random phases: new geometry, a few frames, some cut short or under-flushed.
    phase = 0;
    while (item_count < RANDOM_ITEMS) begin
      idle_on <= !(phase >= 4 && phase <= 7);   // no idling on either side here
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(3, 12);
      h = $urandom_range(3, 8);
      wsel = (w == 3 && $urandom_range(0, 1)) ? $urandom_range(0, 2) : w;
      hsel = (h == 3 && $urandom_range(0, 1)) ? $urandom_range(0, 2) : h;
      w_raw = {5'($urandom), 11'(wsel)};        // bits above the register are dropped
      h_raw = 16'(hsel);
      case ($urandom_range(0, 3))
        0: begin
          write_reg(REG_FRAME_WIDTH, w_raw);
          h = cur_h;
        end
        1: begin
          write_reg(REG_FRAME_HEIGHT, h_raw);
          w = cur_w;
        end
        default: begin
          write_reg(REG_FRAME_WIDTH, w_raw);
          write_reg(REG_FRAME_HEIGHT, h_raw);
        end
      endcase
      cur_w = w;
      cur_h = h;

      frames = $urandom_range(1, 3);
      cut = 1'b0;
      for (int f = 0; f < frames && !cut; f++) begin
        case ($urandom_range(0, 11))
          0: begin
            // frame left unfinished; the next register write aborts it
            send_samples($urandom_range(1, w * h - 1));
            cut = 1'b1;
          end
          1: begin
            // short flush tail: a following frame's first samples finish it, or the next register write aborts it
            send_samples(w * h);
            send_flushes($urandom_range(0, w));
          end
          default: begin
            send_samples(w * h);
            send_flushes(w + 1);
          end
        endcase
      end
      wait_idle();
      phase++;
    end
    idle_on <= 1'b1;

    // Width register at its top (clamped to the line store depth) and minimum height;
    // part of the first row only, the next register write aborts the frame.
    write_reg(REG_FRAME_WIDTH, 16'hFFFF);
    write_reg(REG_FRAME_HEIGHT, 16'h0003);
    send_samples(40);
    wait_idle();

    // Tallest frame, run part way only. Width value carries junk above bit 10.
    // Midway a write to the unused index must not disturb the frame.
    write_reg(REG_FRAME_WIDTH, 16'hF804);
    write_reg(REG_FRAME_HEIGHT, 16'hFFFF);
    send_samples(48);
    wait_idle();
    write_reg(REG_UNUSED, 16'hFFFF);
    send_samples(52);
    wait_idle();

    if (sb.errors == 0 && sb.expected_pixels.size() == 0) begin
      $display("binomial_smooth_3x3 verification clean");
    end else begin
      $display("binomial_smooth_3x3 verification failed");
    end
    $finish;
  end

endmodule
